// ----- sv/mcdq_pkg.sv -----
package mcdq_pkg;

  localparam int KIND_BITS = 2;
  localparam int CLASS_BITS = 5;
  localparam int OUTCOME_BITS = 3;
  localparam int QCOUNT_BITS = 4;

  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [OUTCOME_BITS-1:0] outcome_t;

  localparam kind_t KIND_ADD_TAIL = 2'd0;
  localparam kind_t KIND_ADD_HEAD = 2'd1;
  localparam kind_t KIND_TAKE = 2'd2;

  localparam outcome_t OUT_ADDED = 3'd0;
  localparam outcome_t OUT_FULL = 3'd1;
  localparam outcome_t OUT_SERVED = 3'd2;
  localparam outcome_t OUT_EMPTY = 3'd3;
  localparam outcome_t OUT_BAD = 3'd4;

endpackage

// ----- sv/multi_class_deque_urgent_front.sv -----
// bank of bounded per-class queues with urgent insertion at the head
//
// input channel: in_valid / in_stall with kind, class_index, entry_tag.
// kind 0 appends the tag at the tail, kind 1 inserts it at the head as
// urgent, kind 2 takes the head. every item gives exactly one result on the
// output channel (out_valid / out_stall): outcome, served_tag, served_urgent
// and queue_count, the fill of the addressed queue afterwards (0 if bad).
// a result passes the s1 stage registers and then the output registers.
// throughput: one item per cycle unless the receiver stalls, set by the
// single read-modify-write of one queue row in the row memory; back-to-back
// items on one class are served by a bypass of the row just written.
// reset: all queues read as empty at once through one valid bit per class;
// no clearing pass, the first item may be sent right after reset.
// when the receiver stalls, the whole pipe holds and in_stall rises in the
// same cycle; nothing is dropped or repeated.
module multi_class_deque_urgent_front
  import mcdq_pkg::*;
#(
  parameter int NUM_CLASSES = 32,
  parameter int QUEUE_DEPTH = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_BITS-1:0]    kind,
  input  logic [CLASS_BITS-1:0]   class_index,
  input  logic [TAG_BITS-1:0]     entry_tag,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUTCOME_BITS-1:0] outcome,
  output logic [TAG_BITS-1:0]     served_tag,
  output logic                    served_urgent,
  output logic [QCOUNT_BITS-1:0]  queue_count
);

  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [NW-1:0]                          count;
    logic [QUEUE_DEPTH-1:0]                 urg;
    logic [QUEUE_DEPTH-1:0][TAG_BITS-1:0]   tags;
  } row_t;

  logic en;

  logic                  s1_valid;
  kind_t                 s1_kind;
  logic [CLASS_BITS-1:0] s1_cls;
  logic [TAG_BITS-1:0]   s1_tag;

  logic [NUM_CLASSES-1:0] row_valid;
  logic                   byp_valid;
  logic [CW-1:0]          byp_idx;
  row_t                   byp_row;

  row_t          ram_rdata;
  row_t          row_cur;
  row_t          row_next;
  logic [CW-1:0] s1_idx;
  logic          in_range;
  logic          wr;
  logic [NW-1:0] fill;

  outcome_t             res_outcome;
  logic [TAG_BITS-1:0]  res_tag;
  logic                 res_urgent;
  logic [NW-1:0]        res_count;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind <= kind;
      s1_cls <= class_index;
      s1_tag <= entry_tag;
    end
  end

  mcdq_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(NUM_CLASSES)
  ) u_rows (
    .clk  (clk),
    .we   (en && wr),
    .waddr(s1_idx),
    .wdata(row_next),
    .re   (en),
    .raddr(CW'(class_index)),
    .rdata(ram_rdata)
  );

  assign s1_idx = CW'(s1_cls);
  assign in_range = (32'(s1_cls) < NUM_CLASSES);

  always_comb begin
    if (byp_valid && (byp_idx == s1_idx)) begin
      row_cur = byp_row;
    end else if (in_range && row_valid[s1_idx]) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  assign fill = row_cur.count;

  always_comb begin
    row_next = row_cur;
    wr = 1'b0;
    res_outcome = OUT_BAD;
    res_tag = '0;
    res_urgent = 1'b0;
    res_count = '0;
    if (in_range) begin
      case (s1_kind)
        KIND_TAKE: begin
          if (fill == '0) begin
            res_outcome = OUT_EMPTY;
          end else begin
            res_outcome = OUT_SERVED;
            res_tag = row_cur.tags[0];
            res_urgent = row_cur.urg[0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              row_next.tags[i] = row_cur.tags[i+1];
              row_next.urg[i] = row_cur.urg[i+1];
            end
            row_next.count = fill - NW'(1);
            res_count = fill - NW'(1);
            wr = s1_valid;
          end
        end
        KIND_ADD_TAIL: begin
          if (fill == NW'(QUEUE_DEPTH)) begin
            res_outcome = OUT_FULL;
            res_count = fill;
          end else begin
            res_outcome = OUT_ADDED;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (fill == NW'(i)) begin
                row_next.tags[i] = s1_tag;
                row_next.urg[i] = 1'b0;
              end
            end
            row_next.count = fill + NW'(1);
            res_count = fill + NW'(1);
            wr = s1_valid;
          end
        end
        KIND_ADD_HEAD: begin
          if (fill == NW'(QUEUE_DEPTH)) begin
            res_outcome = OUT_FULL;
            res_count = fill;
          end else begin
            res_outcome = OUT_ADDED;
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
              row_next.tags[i] = row_cur.tags[i-1];
              row_next.urg[i] = row_cur.urg[i-1];
            end
            row_next.tags[0] = s1_tag;
            row_next.urg[0] = 1'b1;
            row_next.count = fill + NW'(1);
            res_count = fill + NW'(1);
            wr = s1_valid;
          end
        end
        default: begin
          res_outcome = OUT_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      byp_valid <= 1'b0;
    end else if (en) begin
      if (wr) begin
        row_valid[s1_idx] <= 1'b1;
      end
      byp_valid <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_idx <= s1_idx;
      byp_row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outcome <= res_outcome;
      served_tag <= res_tag;
      served_urgent <= res_urgent;
      queue_count <= QCOUNT_BITS'(res_count);
    end
  end

`ifndef SYNTHESIS
  a_unserved_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome != OUT_SERVED)) |-> ((served_tag == '0) && !served_urgent))
    else $error("served fields set on a result that served nothing");

  a_bad_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((outcome == OUT_BAD) || (outcome == OUT_EMPTY))) |-> (queue_count == '0))
    else $error("nonzero count on a bad or empty result");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_FULL)) |-> (queue_count == QCOUNT_BITS'(QUEUE_DEPTH)))
    else $error("full reject with a count other than the depth");

  a_bypass_row: assert property (@(posedge clk) disable iff (rst)
    byp_valid |-> row_valid[byp_idx])
    else $error("bypass row for a class never written");
`endif

endmodule

// ----- sv/mcdq_ram.sv -----
module mcdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- test/multi_class_deque_urgent_front_tb.sv -----
`timescale 1ns / 100ps

module multi_class_deque_urgent_front_tb;
  import mcdq_pkg::*;

  localparam int NUM_CLASSES = 32;
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_BITS = 16;
  localparam int N_DIR = 25;
  localparam int N_RANDOM = 1500;
  localparam int HOLD_CYCLES = 300;
  localparam kind_t KIND_UNUSED = 2'd3;

  typedef struct packed {
    outcome_t                 outcome;
    logic [TAG_BITS-1:0]      tag;
    logic                     urgent;
    logic [QCOUNT_BITS-1:0]   count;
  } deque_result_t;

  typedef struct {
    kind_t                    kind;
    logic [CLASS_BITS-1:0]    cls;
    logic [TAG_BITS-1:0]      tag;
    bit                       fixed;
    deque_result_t            want;
  } stim_row_t;

  localparam deque_result_t NO_CHECK = '{OUT_ADDED, 16'h0000, 1'b0, 4'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_BITS-1:0] kind = KIND_TAKE;
  logic [CLASS_BITS-1:0] class_index = '0;
  logic [TAG_BITS-1:0] entry_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUTCOME_BITS-1:0] outcome;
  logic [TAG_BITS-1:0] served_tag;
  logic served_urgent;
  logic [QCOUNT_BITS-1:0] queue_count;

  bit row_fixed = 1'b0;
  deque_result_t row_want = NO_CHECK;

  logic [TAG_BITS-1:0] q_tag [NUM_CLASSES][QUEUE_DEPTH];
  logic q_urgent [NUM_CLASSES][QUEUE_DEPTH];
  int q_fill [NUM_CLASSES];

  deque_result_t expected_results [$];
  stim_row_t dir_rows [N_DIR];
  int mismatches = 0;
  int rx_count = 0;
  bit hold_on = 1'b0;

  multi_class_deque_urgent_front #(
    .NUM_CLASSES(NUM_CLASSES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .class_index(class_index),
    .entry_tag(entry_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .outcome(outcome),
    .served_tag(served_tag),
    .served_urgent(served_urgent),
    .queue_count(queue_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deque_result_t predict_deque_op(kind_t k, logic [CLASS_BITS-1:0] c,
                                                     logic [TAG_BITS-1:0] t);
    deque_result_t r;
    int n;
    r = '{OUT_BAD, '0, 1'b0, '0};
    if (c < NUM_CLASSES) begin
      n = q_fill[c];
      if (k == KIND_TAKE) begin
        if (n == 0) begin
          r = '{OUT_EMPTY, '0, 1'b0, '0};
        end else begin
          r = '{OUT_SERVED, q_tag[c][0], q_urgent[c][0], QCOUNT_BITS'(n - 1)};
          for (int i = 0; i + 1 < n; i++) begin
            q_tag[c][i] = q_tag[c][i+1];
            q_urgent[c][i] = q_urgent[c][i+1];
          end
          q_fill[c] = n - 1;
        end
      end else if (k == KIND_ADD_TAIL || k == KIND_ADD_HEAD) begin
        if (n >= QUEUE_DEPTH) begin
          r = '{OUT_FULL, '0, 1'b0, QCOUNT_BITS'(n)};
        end else begin
          if (k == KIND_ADD_TAIL) begin
            q_tag[c][n] = t;
            q_urgent[c][n] = 1'b0;
          end else begin
            for (int i = n; i > 0; i--) begin
              q_tag[c][i] = q_tag[c][i-1];
              q_urgent[c][i] = q_urgent[c][i-1];
            end
            q_tag[c][0] = t;
            q_urgent[c][0] = 1'b1;
          end
          q_fill[c] = n + 1;
          r = '{OUT_ADDED, '0, 1'b0, QCOUNT_BITS'(n + 1)};
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    deque_result_t pred;
    deque_result_t got;
    deque_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = predict_deque_op(kind, class_index, entry_tag);
        expected_results.push_back(row_fixed ? row_want : pred);
      end
      if (out_valid && !out_stall) begin
        rx_count++;
        got = '{outcome, served_tag, served_urgent, queue_count};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item pending: outcome %0d tag %h urgent %0d count %0d",
                     $realtime, got.outcome, got.tag, got.urgent, got.count);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected outcome %0d tag %h urgent %0d count %0d, got outcome %0d tag %h urgent %0d count %0d",
                       $realtime, want.outcome, want.tag, want.urgent, want.count,
                       got.outcome, got.tag, got.urgent, got.count);
          end
        end
      end
    end
  end

  task automatic offer_item(kind_t k, logic [CLASS_BITS-1:0] c, logic [TAG_BITS-1:0] t,
                            bit fixed, deque_result_t want, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    class_index <= c;
    entry_tag <= t;
    row_fixed <= fixed;
    row_want <= want;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin : receiver
    int w;
    int served;
    bit quiet;
    bit held;
    served = 0;
    quiet = 1'b0;
    held = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (served % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (!held && rx_count >= 300) begin
        held = 1'b1;
        hold_on = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else begin
        w = quiet ? 0 : $urandom_range(0, 14);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      served++;
    end
  end

  initial begin : sender
    kind_t k;
    logic [CLASS_BITS-1:0] c;
    logic [CLASS_BITS-1:0] hot [4];
    int add_pct;
    int r;
    int gap;
    bit quiet;

    for (int i = 0; i < NUM_CLASSES; i++) q_fill[i] = 0;

    dir_rows = '{
      '{KIND_TAKE,     5'd0,  16'h0000, 1'b1, '{OUT_EMPTY,  16'h0000, 1'b0, 4'd0}},
      '{KIND_UNUSED,   5'd0,  16'hffff, 1'b1, '{OUT_BAD,    16'h0000, 1'b0, 4'd0}},
      '{KIND_UNUSED,   5'd31, 16'h1234, 1'b1, '{OUT_BAD,    16'h0000, 1'b0, 4'd0}},
      '{KIND_ADD_TAIL, 5'd31, 16'hffff, 1'b1, '{OUT_ADDED,  16'h0000, 1'b0, 4'd1}},
      '{KIND_ADD_HEAD, 5'd31, 16'h0000, 1'b1, '{OUT_ADDED,  16'h0000, 1'b0, 4'd2}},
      '{KIND_TAKE,     5'd31, 16'hffff, 1'b1, '{OUT_SERVED, 16'h0000, 1'b1, 4'd1}},
      '{KIND_TAKE,     5'd31, 16'h0000, 1'b1, '{OUT_SERVED, 16'hffff, 1'b0, 4'd0}},
      '{KIND_TAKE,     5'd31, 16'h0000, 1'b1, '{OUT_EMPTY,  16'h0000, 1'b0, 4'd0}},
      '{KIND_ADD_TAIL, 5'd10, 16'ha5a5, 1'b0, NO_CHECK},
      '{KIND_ADD_HEAD, 5'd10, 16'h5a5a, 1'b0, NO_CHECK},
      '{KIND_ADD_TAIL, 5'd10, 16'h0001, 1'b0, NO_CHECK},
      '{KIND_ADD_HEAD, 5'd10, 16'h8000, 1'b0, NO_CHECK},
      '{KIND_ADD_TAIL, 5'd10, 16'h7fff, 1'b0, NO_CHECK},
      '{KIND_ADD_HEAD, 5'd10, 16'hfffe, 1'b0, NO_CHECK},
      '{KIND_ADD_TAIL, 5'd10, 16'h00ff, 1'b0, NO_CHECK},
      '{KIND_ADD_HEAD, 5'd10, 16'hff00, 1'b0, NO_CHECK},
      '{KIND_ADD_TAIL, 5'd10, 16'h1111, 1'b1, '{OUT_FULL,   16'h0000, 1'b0, 4'd8}},
      '{KIND_ADD_HEAD, 5'd10, 16'h2222, 1'b1, '{OUT_FULL,   16'h0000, 1'b0, 4'd8}},
      '{KIND_TAKE,     5'd10, 16'h0000, 1'b0, NO_CHECK},
      '{KIND_TAKE,     5'd10, 16'hffff, 1'b0, NO_CHECK},
      '{KIND_ADD_TAIL, 5'd21, 16'hc3c3, 1'b0, NO_CHECK},
      '{KIND_TAKE,     5'd10, 16'h0000, 1'b0, NO_CHECK},
      '{KIND_TAKE,     5'd21, 16'h0000, 1'b0, NO_CHECK},
      '{KIND_UNUSED,   5'd10, 16'h0000, 1'b1, '{OUT_BAD,    16'h0000, 1'b0, 4'd0}},
      '{KIND_TAKE,     5'd10, 16'h0000, 1'b0, NO_CHECK}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      offer_item(dir_rows[i].kind, dir_rows[i].cls, dir_rows[i].tag, dir_rows[i].fixed,
                 dir_rows[i].want, $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0);

    add_pct = 50;
    quiet = 1'b0;
    foreach (hot[j]) hot[j] = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      // new phase: hot classes, add/take balance, sender idling on or off
      if (i % 60 == 0) begin
        foreach (hot[j]) hot[j] = CLASS_BITS'($urandom_range(0, NUM_CLASSES - 1));
        case ($urandom_range(0, 2))
          0: add_pct = 30;
          1: add_pct = 50;
          default: add_pct = 72;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3)
        k = KIND_UNUSED;
      else if (r < 3 + add_pct)
        k = $urandom_range(0, 1) ? KIND_ADD_HEAD : KIND_ADD_TAIL;
      else
        k = KIND_TAKE;
      c = ($urandom_range(0, 99) < 80) ? hot[$urandom_range(0, 3)]
                                       : CLASS_BITS'($urandom_range(0, NUM_CLASSES - 1));
      gap = (quiet || hold_on) ? 0 : $urandom_range(0, 14);
      offer_item(k, c, TAG_BITS'($urandom), 1'b0, NO_CHECK, gap);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
